// ----- sv/i2cdrs_pkg.sv -----
// Package for the I2C device register store: command codes, controller states
// and the transaction token that walks the row of device cells.
// No dependencies.
package i2cdrs_pkg;

  localparam int CMD_W = 3;
  localparam int ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int ENTRY_W = 2 * BYTE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_CLOSE   = 3'd1,
    CMD_SET_PTR = 3'd2,
    CMD_READ    = 3'd3,
    CMD_STORE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [ADDR_W-1:0] dev_addr;
    logic [BYTE_W-1:0] reg_addr;
  } tok_t;

endpackage

// ----- sv/i2cdrs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module i2cdrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/i2cdrs_dev_cell.sv -----
// One device cell: address, valid bit, register pointer and fill count of one
// emulated target. Depends on i2cdrs_pkg; the cells form a row in the top level.
module i2cdrs_dev_cell #(
  parameter int IDX = 0,
  parameter int DEV_W = 3,
  parameter int CNT_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  i2cdrs_pkg::tok_t           tok_i,
  input  logic                       found_i,
  input  logic [DEV_W-1:0]           fidx_i,
  input  logic [i2cdrs_pkg::BYTE_W-1:0] fptr_i,
  input  logic [CNT_W-1:0]           fcnt_i,
  input  logic                       free_i,
  input  logic [DEV_W-1:0]           freeidx_i,
  input  logic                       upd_en,
  input  logic                       upd_alloc,
  input  logic [DEV_W-1:0]           upd_idx,
  input  logic [CNT_W-1:0]           upd_cnt,
  input  logic [i2cdrs_pkg::ADDR_W-1:0] upd_addr,
  output i2cdrs_pkg::tok_t           tok_o,
  output logic                       found_o,
  output logic [DEV_W-1:0]           fidx_o,
  output logic [i2cdrs_pkg::BYTE_W-1:0] fptr_o,
  output logic [CNT_W-1:0]           fcnt_o,
  output logic                       free_o,
  output logic [DEV_W-1:0]           freeidx_o
);
  import i2cdrs_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hit_here, free_here;

  tok_t              tok_r;
  logic              found_r, free_r;
  logic [DEV_W-1:0]  fidx_r, freeidx_r;
  logic [BYTE_W-1:0] fptr_r;
  logic [CNT_W-1:0]  fcnt_r;

  assign hit_here = tok_i.vld && valid_r && (id_r == tok_i.dev_addr) && !found_i;
  assign free_here = tok_i.vld && !valid_r && !free_i;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt = id_r;
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    if (upd_en && (upd_idx == DEV_W'(IDX))) begin
      if (upd_alloc) begin
        valid_nxt = 1'b1;
        id_nxt = upd_addr;
      end
      cnt_nxt = upd_cnt;
    end else if (tok_i.vld) begin
      unique case (tok_i.cmd)
        CMD_CLEAR: begin
          valid_nxt = 1'b0;
          ptr_nxt = '0;
        end
        CMD_CLOSE: begin
          valid_nxt = 1'b0;
        end
        CMD_SET_PTR: begin
          if (hit_here) begin
            ptr_nxt = tok_i.reg_addr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r <= '0;
      tok_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r <= ptr_nxt;
      tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    cnt_r <= cnt_nxt;
    found_r <= found_i | hit_here;
    fidx_r <= hit_here ? DEV_W'(IDX) : fidx_i;
    fptr_r <= hit_here ? ptr_r : fptr_i;
    fcnt_r <= hit_here ? cnt_r : fcnt_i;
    free_r <= free_i | free_here;
    freeidx_r <= free_here ? DEV_W'(IDX) : freeidx_i;
  end

  assign tok_o = tok_r;
  assign found_o = found_r;
  assign fidx_o = fidx_r;
  assign fptr_o = fptr_r;
  assign fcnt_o = fcnt_r;
  assign free_o = free_r;
  assign freeidx_o = freeidx_r;

endmodule

// ----- sv/i2c_device_register_store.sv -----
// Top level of the I2C device register store: controller, row of device cells
// and the register entry RAM. Depends on i2cdrs_pkg, i2cdrs_dev_cell, i2cdrs_ram.
//
// The block emulates NUM_DEVICES I2C targets, each with up to REGS_PER_DEVICE
// registers. One command transaction enters on the in_ stream and produces
// exactly one result transaction on the out_ stream.
// A command first walks the row of device cells, one cell per cycle, which
// finds the addressed device and the first free device slot. A bus read or a
// back-door store to a known device then scans that device's filled register
// entries in the RAM, one entry per cycle with a registered read.
// One command is in progress at a time; the next is taken as soon as the
// previous one has written its result to the output register.
// A result waiting on a stalled receiver holds out_tdata and out_tuser; the
// block then accepts one more command and holds its result until the first
// one is taken. After reset all devices and registers are empty and the block
// is ready at once.
module i2c_device_register_store #(
  parameter int NUM_DEVICES = 8,
  parameter int REGS_PER_DEVICE = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // cmd[2:0], dev_addr[9:3], reg_addr[17:10], wr_data[25:18], zero fill.
  input  logic [i2cdrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // read_data[7:0].
  output logic [i2cdrs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // hit[0].
  output logic                                  out_tuser
);
  import i2cdrs_pkg::*;

  localparam int DEV_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int CNT_W = $clog2(REGS_PER_DEVICE + 1);
  localparam int SLOTS = NUM_DEVICES * REGS_PER_DEVICE;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  tok_t              tok_c     [NUM_DEVICES+1];
  logic              found_c   [NUM_DEVICES+1];
  logic [DEV_W-1:0]  fidx_c    [NUM_DEVICES+1];
  logic [BYTE_W-1:0] fptr_c    [NUM_DEVICES+1];
  logic [CNT_W-1:0]  fcnt_c    [NUM_DEVICES+1];
  logic              free_c    [NUM_DEVICES+1];
  logic [DEV_W-1:0]  freeidx_c [NUM_DEVICES+1];

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] ra_r, wd_r;
  logic              found_r, free_r;
  logic [DEV_W-1:0]  fidx_r, freeidx_r;
  logic [CNT_W-1:0]  fcnt_r;
  logic [BYTE_W-1:0] key_r;
  logic [SLOT_W-1:0] base_r;
  logic [CNT_W-1:0]  issue_r, cmp_idx_r, match_idx_r;
  logic              cmp_vld_r, match_r;
  logic [BYTE_W-1:0] match_byte_r;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_hit_r;

  logic              in_acc, out_free, chain_done, fin_go;
  logic              scan_hit, scan_end, scan_issue;
  logic [ENTRY_W-1:0] rd_data;
  logic [SLOT_W-1:0] raddr;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic              upd_en, upd_alloc;
  logic [DEV_W-1:0]  upd_idx;
  logic [CNT_W-1:0]  upd_cnt;
  logic              res_hit;
  logic [BYTE_W-1:0] res_data;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign chain_done = (state_r == ST_CHAIN) && tok_c[NUM_DEVICES].vld;
  assign fin_go = (state_r == ST_FINISH) && out_free;
  assign upd_idx = found_r ? fidx_r : freeidx_r;

  assign tok_c[0] = '{vld: in_acc, cmd: cmd_t'(in_tdata[2:0]),
                      dev_addr: in_tdata[9:3], reg_addr: in_tdata[17:10]};
  assign found_c[0] = 1'b0;
  assign fidx_c[0] = '0;
  assign fptr_c[0] = '0;
  assign fcnt_c[0] = '0;
  assign free_c[0] = 1'b0;
  assign freeidx_c[0] = '0;

  for (genvar g = 0; g < NUM_DEVICES; g++) begin : g_cell
    i2cdrs_dev_cell #(
      .IDX  (g),
      .DEV_W(DEV_W),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok_c[g]),
      .found_i  (found_c[g]),
      .fidx_i   (fidx_c[g]),
      .fptr_i   (fptr_c[g]),
      .fcnt_i   (fcnt_c[g]),
      .free_i   (free_c[g]),
      .freeidx_i(freeidx_c[g]),
      .upd_en   (upd_en),
      .upd_alloc(upd_alloc),
      .upd_idx  (upd_idx),
      .upd_cnt  (upd_cnt),
      .upd_addr (addr_r),
      .tok_o    (tok_c[g+1]),
      .found_o  (found_c[g+1]),
      .fidx_o   (fidx_c[g+1]),
      .fptr_o   (fptr_c[g+1]),
      .fcnt_o   (fcnt_c[g+1]),
      .free_o   (free_c[g+1]),
      .freeidx_o(freeidx_c[g+1])
    );
  end

  i2cdrs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS),
    .AW   (SLOT_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({ra_r, wd_r}),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign scan_hit = cmp_vld_r && (rd_data[ENTRY_W-1:BYTE_W] == key_r);
  assign scan_end = !cmp_vld_r && (issue_r == fcnt_r);
  assign scan_issue = (state_r == ST_SCAN) && !scan_hit && (issue_r != fcnt_r);
  assign raddr = base_r + SLOT_W'(issue_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHAIN;
        end
      end
      ST_CHAIN: begin
        if (chain_done) begin
          if (found_c[NUM_DEVICES] && (cmd_r == CMD_READ || cmd_r == CMD_STORE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_hit = 1'b0;
    res_data = '0;
    we = 1'b0;
    waddr = base_r;
    upd_en = 1'b0;
    upd_alloc = 1'b0;
    upd_cnt = fcnt_r + CNT_W'(1);
    unique case (cmd_r)
      CMD_SET_PTR: begin
        res_hit = found_r;
      end
      CMD_READ: begin
        if (match_r) begin
          res_hit = 1'b1;
          res_data = match_byte_r;
        end
      end
      CMD_STORE: begin
        if (found_r) begin
          if (match_r) begin
            res_hit = 1'b1;
            we = fin_go;
            waddr = base_r + SLOT_W'(match_idx_r);
          end else if (fcnt_r != CNT_W'(REGS_PER_DEVICE)) begin
            res_hit = 1'b1;
            we = fin_go;
            waddr = base_r + SLOT_W'(fcnt_r);
            upd_en = fin_go;
          end
        end else if (free_r) begin
          res_hit = 1'b1;
          we = fin_go;
          upd_en = fin_go;
          upd_alloc = 1'b1;
          upd_cnt = CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_tdata[2:0]);
      addr_r <= in_tdata[9:3];
      ra_r <= in_tdata[17:10];
      wd_r <= in_tdata[25:18];
    end
    if (chain_done) begin
      found_r <= found_c[NUM_DEVICES];
      fidx_r <= fidx_c[NUM_DEVICES];
      fcnt_r <= fcnt_c[NUM_DEVICES];
      free_r <= free_c[NUM_DEVICES];
      freeidx_r <= freeidx_c[NUM_DEVICES];
      key_r <= (cmd_r == CMD_READ) ? fptr_c[NUM_DEVICES] : ra_r;
      base_r <= found_c[NUM_DEVICES]
              ? SLOT_W'(fidx_c[NUM_DEVICES]) * SLOT_W'(REGS_PER_DEVICE)
              : SLOT_W'(freeidx_c[NUM_DEVICES]) * SLOT_W'(REGS_PER_DEVICE);
      issue_r <= '0;
      cmp_vld_r <= 1'b0;
      match_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      cmp_vld_r <= scan_issue;
      cmp_idx_r <= issue_r;
      if (scan_issue) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      if (scan_hit) begin
        match_r <= 1'b1;
        match_idx_r <= cmp_idx_r;
        match_byte_r <= rd_data[BYTE_W-1:0];
      end
    end
    if (fin_go) begin
      out_data_r <= res_data;
      out_hit_r <= res_hit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_hit_r;

endmodule

// ----- sv/i2cdrs_checker.sv -----
// Port-level checker for the I2C device register store and its bind statement.
// Depends only on the top level's ports.
module i2cdrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Only one command is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while a command was in progress");

  // Every result belongs to an accepted command.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != 2'd0))
    else $error("result without an outstanding command");

  // At most one command in progress and one result waiting.
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many outstanding commands");

  // A miss always reports a zero byte.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0))
    else $error("nonzero data on a miss");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind i2c_device_register_store i2cdrs_checker u_i2cdrs_checker (.*);
